// ===== design/button_click_press_detector_macros.svh =====
// assertion helpers for the button click press detector
`ifndef BUTTON_CLICK_PRESS_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_PRESS_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

`define BCPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcpd assertion failed");

`define BCPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcpd assertion failed");

`else

`define BCPD_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define BCPD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/bcpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bcpd_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLICK      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_LOW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DBL_ENABLE = 3'd4;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [15:0] CLICK_RESET    = 16'd400;
   localparam logic [15:0] PRESS_RESET    = 16'd800;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_PRESSED  = 3'd1,
      PH_RELEASED = 3'd2,
      PH_SECOND   = 3'd3,
      PH_LONG     = 3'd4
   } phase_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] click_ms;
      logic [15:0] press_ms;
      logic        active_low;
      logic        double_click_enable;
   } cfg_type;

   typedef struct packed {
      logic        click_event;
      logic        double_click_event;
      logic        long_start_event;
      logic        long_stop_event;
      logic        long_during_event;
      logic        long_pressed;
      logic [31:0] press_duration_ms;
      logic [31:0] since_start_ms;
      phase_type   fsm_state;
   } res_type;

endpackage

`default_nettype wire

// ===== design/bcpd_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcpd_csr
   import bcpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [CSR_IDX_W-1:0]   idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_DEBOUNCE:   cfg_in.debounce_ms         = csr_pwdata[15:0];
            REG_CLICK:      cfg_in.click_ms            = csr_pwdata[15:0];
            REG_PRESS:      cfg_in.press_ms            = csr_pwdata[15:0];
            REG_ACTIVE_LOW: cfg_in.active_low          = csr_pwdata[0];
            REG_DBL_ENABLE: cfg_in.double_click_enable = csr_pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms         <= DEBOUNCE_RESET;
         cfg_ff.click_ms            <= CLICK_RESET;
         cfg_ff.press_ms            <= PRESS_RESET;
         cfg_ff.active_low          <= 1'b0;
         cfg_ff.double_click_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (idx)
         REG_DEBOUNCE:   csr_prdata = {16'd0, cfg_ff.debounce_ms};
         REG_CLICK:      csr_prdata = {16'd0, cfg_ff.click_ms};
         REG_PRESS:      csr_prdata = {16'd0, cfg_ff.press_ms};
         REG_ACTIVE_LOW: csr_prdata = {31'd0, cfg_ff.active_low};
         REG_DBL_ENABLE: csr_prdata = {31'd0, cfg_ff.double_click_enable};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/bcpd_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcpd_fsm
   import bcpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        step_en,
   input  wire logic        pin_level,
   input  wire logic [31:0] now_ms,
   output res_type          res
);

   phase_type   phase_ff;
   phase_type   phase_in;
   logic [31:0] press_start_ff;
   logic [31:0] press_start_in;
   logic [31:0] press_stop_ff;
   logic [31:0] press_stop_in;
   logic        long_ff;
   logic        long_in;

   logic        active;
   logic [31:0] elapsed;
   logic [31:0] debounce;
   logic [31:0] click_win;
   logic [31:0] press_win;
   logic        ev_click;
   logic        ev_dbl;
   logic        ev_lstart;
   logic        ev_lstop;
   logic        ev_ldur;

   assign active    = cfg.active_low ? ~pin_level : pin_level;
   assign elapsed   = now_ms - press_start_ff;
   assign debounce  = {16'd0, cfg.debounce_ms};
   assign click_win = {16'd0, cfg.click_ms};
   assign press_win = {16'd0, cfg.press_ms};

   // next phase
   always_comb begin
      phase_in = PH_IDLE;
      case (phase_ff)
         PH_IDLE: begin
            phase_in = active ? PH_PRESSED : PH_IDLE;
         end
         PH_PRESSED: begin
            if (!active && elapsed < debounce) begin
               phase_in = PH_IDLE;
            end else if (!active) begin
               phase_in = PH_RELEASED;
            end else if (elapsed > press_win) begin
               phase_in = PH_LONG;
            end else begin
               phase_in = PH_PRESSED;
            end
         end
         PH_RELEASED: begin
            if (!cfg.double_click_enable || elapsed > click_win) begin
               phase_in = PH_IDLE;
            end else if (active && elapsed > debounce) begin
               phase_in = PH_SECOND;
            end else begin
               phase_in = PH_RELEASED;
            end
         end
         PH_SECOND: begin
            phase_in = (!active && elapsed > debounce) ? PH_IDLE : PH_SECOND;
         end
         PH_LONG: begin
            phase_in = active ? PH_LONG : PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // events and timestamps
   always_comb begin
      press_start_in = press_start_ff;
      press_stop_in  = press_stop_ff;
      long_in        = long_ff;
      ev_click       = 1'b0;
      ev_dbl         = 1'b0;
      ev_lstart      = 1'b0;
      ev_lstop       = 1'b0;
      ev_ldur        = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (active) begin
               press_start_in = now_ms;
            end
         end
         PH_PRESSED: begin
            if (!active && elapsed >= debounce) begin
               press_stop_in = now_ms;
            end else if (active && elapsed > press_win) begin
               long_in   = 1'b1;
               ev_lstart = 1'b1;
            end
         end
         PH_RELEASED: begin
            if (!cfg.double_click_enable || elapsed > click_win) begin
               ev_click = 1'b1;
            end else if (active && elapsed > debounce) begin
               press_start_in = now_ms;
            end
         end
         PH_SECOND: begin
            if (!active && elapsed > debounce) begin
               press_stop_in = now_ms;
               ev_dbl        = cfg.double_click_enable;
            end
         end
         PH_LONG: begin
            if (!active) begin
               long_in       = 1'b0;
               press_stop_in = now_ms;
               ev_lstop      = 1'b1;
            end else begin
               long_in = 1'b1;
               ev_ldur = 1'b1;
            end
         end
         default: begin
            long_in = long_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         press_start_ff <= '0;
         press_stop_ff  <= '0;
         long_ff        <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         press_start_ff <= press_start_in;
         press_stop_ff  <= press_stop_in;
         long_ff        <= long_in;
      end
   end

   always_comb begin
      res.click_event        = ev_click;
      res.double_click_event = ev_dbl;
      res.long_start_event   = ev_lstart;
      res.long_stop_event    = ev_lstop;
      res.long_during_event  = ev_ldur;
      res.long_pressed       = long_in;
      res.press_duration_ms  = press_stop_in - press_start_in;
      res.since_start_ms     = now_ms - press_start_in;
      res.fsm_state          = phase_in;
   end

endmodule

`default_nettype wire

// ===== design/button_click_press_detector.sv =====
// Button click, double click and long press detector.
// req channel: one item per tick while req_tready is high, tdata holds the sampled pin level (bit 0) and
// the millisecond time now_ms (bits 32:1); the time wraps modulo 2^32.
// rsp channel: exactly one item per accepted req item, in order, carrying the
// one-tick event flags, the long press flag, press duration, time since press
// start and the phase of the state machine after that tick.
// csr port: APB-style, registers at byte addresses 0 debounce_ms, 4 click_ms,
// 8 press_ms, 12 active_low, 16 double_click_enable; pready is always high.
// Path: an accepted item enters the input register, is stepped through the state
// machine into the result register once that register is free, and is then
// presented on rsp.
// Throughput: one item per cycle while rsp_tready is high, with the state update
// between the input register and the result register.
// Reset: both registers empty, state machine idle, timestamps and long press
// flag cleared, configuration back to 50 / 400 / 800 ms, active high, double
// click off.
// Stall: while rsp_tready is low the result is held; the input register can
// still take one more item, after which req_tready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "button_click_press_detector_macros.svh"

module button_click_press_detector
   import bcpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [0] pin_level, [32:1] now_ms, [39:33] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] click_event, [1] double_click_event, [2] long_start_event,
   // [3] long_stop_event, [4] long_during_event, [5] long_pressed,
   // [37:6] press_duration_ms, [69:38] since_start_ms, [72:70] fsm_state,
   // [79:73] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type     cfg;
   res_type     res;
   res_type     rsp_ff;
   logic        in_valid_ff;
   logic        pin_ff;
   logic [31:0] now_ff;
   logic        out_valid_ff;
   logic        advance;

   bcpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pin_ff <= req_tdata[0];
         now_ff <= req_tdata[32:1];
      end
   end

   bcpd_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step_en   (advance),
      .pin_level (pin_ff),
      .now_ms    (now_ff),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_ff.fsm_state,
                        rsp_ff.since_start_ms,
                        rsp_ff.press_duration_ms,
                        rsp_ff.long_pressed,
                        rsp_ff.long_during_event,
                        rsp_ff.long_stop_event,
                        rsp_ff.long_start_event,
                        rsp_ff.double_click_event,
                        rsp_ff.click_event};

   `BCPD_ASSERT_NEXT(a_advance_fills_out, clock, reset, advance, rsp_tvalid)
   `BCPD_ASSERT_IMPLY(a_one_event, clock, reset, rsp_tvalid, $onehot0(rsp_tdata[4:0]))
   `BCPD_ASSERT_IMPLY(a_long_start, clock, reset,
                      rsp_tvalid && rsp_ff.long_start_event,
                      rsp_ff.fsm_state == PH_LONG && rsp_ff.long_pressed)
   `BCPD_ASSERT_IMPLY(a_long_stop, clock, reset,
                      rsp_tvalid && rsp_ff.long_stop_event,
                      rsp_ff.fsm_state == PH_IDLE && !rsp_ff.long_pressed)

endmodule

`default_nettype wire
